FILE: rtl/ccld_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccld_pkg
// Shared types, codes and helpers of the console command line decoder.
// ----------------------------------------------------------------------------
package ccld_pkg;

    localparam int LINE_CAPACITY_DEF = 63;
    localparam int SNAP_LEN          = 28;
    localparam int PREFIX_LEN        = 9;
    localparam int WORD_MAX          = 12;
    localparam int QUEUE_DEPTH       = 2;
    localparam int RESULT_W          = 55;
    localparam int M_TDATA_W         = 56;

    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7e;
    localparam logic [7:0] CHAR_DEL   = 8'h7f;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DASH  = 8'h2d;
    localparam logic [7:0] CHAR_COLON = 8'h3a;

    // Command words as ASCII, first char in the highest used byte.
    localparam logic [8*WORD_MAX-1:0] W_HELP       = 96'h48454c50;
    localparam logic [8*WORD_MAX-1:0] W_SETTINGS   = 96'h4745545f53455454494e4753;
    localparam logic [8*WORD_MAX-1:0] W_AUDIO      = 96'h4745545f415544494f;
    localparam logic [8*WORD_MAX-1:0] W_NETWORK    = 96'h4745545f4e4554574f524b;
    localparam logic [8*WORD_MAX-1:0] W_WIFI       = 96'h52455345545f57494649;
    localparam logic [8*WORD_MAX-1:0] W_CLK_READ   = 96'h4745545f54494d45;
    // Clock write prefix, trailing space included.
    localparam logic [8*WORD_MAX-1:0] W_CLK_PREFIX = 96'h5345545f54494d4520;

    typedef enum logic [2:0] {
        CMD_HELP     = 3'd0,
        CMD_SETTINGS = 3'd1,
        CMD_AUDIO    = 3'd2,
        CMD_NETWORK  = 3'd3,
        CMD_WIFI     = 3'd4,
        CMD_CLOCK_RD = 3'd5,
        CMD_CLOCK_WR = 3'd6,
        CMD_NONE     = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_LONG = 3'd1,
        ST_UNKNOWN  = 3'd2,
        ST_NO_CLOCK = 3'd3,
        ST_BAD_TIME = 3'd4
    } status_t;

    typedef struct packed {
        logic len4;
        logic len8;
        logic len9;
        logic len10;
        logic len11;
        logic len12;
        logic len28;
        logic len_ge9;
    } len_flags_t;

    // Finished line handed from front to back; chars[0] is the first byte.
    typedef struct packed {
        logic [SNAP_LEN-1:0][7:0] chars;
        logic                     overflow;
        len_flags_t               lens;
    } token_t;

    // Packed from the MSB down, so command lands in the lowest bits.
    typedef struct packed {
        logic [6:0]  second_value;
        logic [6:0]  minute_value;
        logic [6:0]  hour_value;
        logic [6:0]  day_value;
        logic [6:0]  month_value;
        logic [13:0] year_value;
        status_t     status;
        cmd_t        command_code;
    } result_t;

    // Word of n chars: its first char sits in byte n-1.
    function automatic logic word_at(input logic [SNAP_LEN-1:0][7:0] line,
                                     input logic [8*WORD_MAX-1:0] word,
                                     input int n);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < WORD_MAX; i++) begin
            if (i < n) begin
                if (line[i] != word[8*(n-1-i) +: 8]) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic [3:0] digit_val(input logic [7:0] c);
        logic [7:0] d;
        d = c - CHAR_ZERO;
        return d[3:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/ccld_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccld_front
// Byte intake: line editing in a register store, line snapshot on newline.
// ----------------------------------------------------------------------------
module ccld_front import ccld_pkg::*; #(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // rx_byte[7:0]
    input  wire logic       q_full,
    output logic            push,
    output token_t          push_token
);

    localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);
    localparam int SNAP_W = $clog2(SNAP_LEN);

    // only the first SNAP_LEN chars can decide a command
    logic [7:0]       chars_reg [SNAP_LEN];
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic             accept, is_print, do_store;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_print = (s_tdata >= CHAR_SPACE) && (s_tdata <= CHAR_TILDE);
    assign do_store = accept && is_print && (len_reg < LEN_W'(LINE_CAPACITY));

    always_comb begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        push     = 1'b0;
        if (accept) begin
            if (s_tdata == CHAR_BS || s_tdata == CHAR_DEL) begin
                if (len_reg != '0) begin
                    len_next = len_reg - LEN_W'(1);
                end
            end else if (s_tdata == CHAR_LF) begin
                push     = ovf_reg || (len_reg != '0);
                len_next = '0;
                ovf_next = 1'b0;
            end else if (is_print) begin
                if (do_store) begin
                    len_next = len_reg + LEN_W'(1);
                end else begin
                    ovf_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < SNAP_LEN; i++) begin
            push_token.chars[i] = chars_reg[i];
        end
        push_token.overflow     = ovf_reg;
        push_token.lens.len4    = (len_reg == LEN_W'(4));
        push_token.lens.len8    = (len_reg == LEN_W'(8));
        push_token.lens.len9    = (len_reg == LEN_W'(9));
        push_token.lens.len10   = (len_reg == LEN_W'(10));
        push_token.lens.len11   = (len_reg == LEN_W'(11));
        push_token.lens.len12   = (len_reg == LEN_W'(12));
        push_token.lens.len28   = (len_reg == LEN_W'(SNAP_LEN));
        push_token.lens.len_ge9 = (len_reg >= LEN_W'(PREFIX_LEN));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_store && (len_reg < LEN_W'(SNAP_LEN))) begin
            chars_reg[len_reg[SNAP_W-1:0]] <= s_tdata;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ccld_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccld_queue
// Short FIFO of finished lines between front and back.
// ----------------------------------------------------------------------------
module ccld_queue import ccld_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire token_t push_token,
    input  wire logic   pop,
    output logic        full,
    output logic        empty,
    output token_t      head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    token_t           entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ccld_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccld_back
// Command decode of a finished line into the registered result beat.
// ----------------------------------------------------------------------------
module ccld_back import ccld_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   clock_present,
    input  wire logic   q_empty,
    input  wire token_t head,
    output logic        pop,
    output logic        m_tvalid,
    input  wire logic   m_tready,
    output result_t     m_result
);

    logic [SNAP_LEN-1:0][7:0] ln;
    logic    is_help, is_settings, is_audio, is_network, is_wifi, is_get, is_set;
    logic    fmt_ok;
    result_t res;
    logic    out_valid_reg;
    result_t out_data_reg;

    assign ln = head.chars;

    assign is_help     = head.lens.len4  && word_at(ln, W_HELP, 4);
    assign is_settings = head.lens.len12 && word_at(ln, W_SETTINGS, 12);
    assign is_audio    = head.lens.len9  && word_at(ln, W_AUDIO, 9);
    assign is_network  = head.lens.len11 && word_at(ln, W_NETWORK, 11);
    assign is_wifi     = head.lens.len10 && word_at(ln, W_WIFI, 10);
    assign is_get      = head.lens.len8  && word_at(ln, W_CLK_READ, 8);
    assign is_set      = head.lens.len_ge9 && word_at(ln, W_CLK_PREFIX, PREFIX_LEN);

    assign fmt_ok = head.lens.len28
        && ln[13] == CHAR_DASH && ln[16] == CHAR_DASH && ln[19] == CHAR_SPACE
        && ln[22] == CHAR_COLON && ln[25] == CHAR_COLON
        && is_digit(ln[9])  && is_digit(ln[10]) && is_digit(ln[11])
        && is_digit(ln[12]) && is_digit(ln[14]) && is_digit(ln[15])
        && is_digit(ln[17]) && is_digit(ln[18]) && is_digit(ln[20])
        && is_digit(ln[21]) && is_digit(ln[23]) && is_digit(ln[24])
        && is_digit(ln[26]) && is_digit(ln[27]);

    always_comb begin
        res              = '0;
        res.command_code = CMD_NONE;
        res.status       = ST_OK;
        priority if (head.overflow) begin
            res.status = ST_TOO_LONG;
        end else if (is_help) begin
            res.command_code = CMD_HELP;
        end else if (is_settings) begin
            res.command_code = CMD_SETTINGS;
        end else if (is_audio) begin
            res.command_code = CMD_AUDIO;
        end else if (is_network) begin
            res.command_code = CMD_NETWORK;
        end else if (is_wifi) begin
            res.command_code = CMD_WIFI;
        end else if (!is_get && !is_set) begin
            res.status = ST_UNKNOWN;
        end else if (!clock_present) begin
            res.command_code = is_get ? CMD_CLOCK_RD : CMD_CLOCK_WR;
            res.status       = ST_NO_CLOCK;
        end else if (is_get) begin
            res.command_code = CMD_CLOCK_RD;
        end else if (!fmt_ok) begin
            res.command_code = CMD_CLOCK_WR;
            res.status       = ST_BAD_TIME;
        end else begin
            res.command_code = CMD_CLOCK_WR;
            res.year_value   = 14'(digit_val(ln[9]))  * 14'd1000
                             + 14'(digit_val(ln[10])) * 14'd100
                             + 14'(digit_val(ln[11])) * 14'd10
                             + 14'(digit_val(ln[12]));
            res.month_value  = 7'(digit_val(ln[14])) * 7'd10 + 7'(digit_val(ln[15]));
            res.day_value    = 7'(digit_val(ln[17])) * 7'd10 + 7'(digit_val(ln[18]));
            res.hour_value   = 7'(digit_val(ln[20])) * 7'd10 + 7'(digit_val(ln[21]));
            res.minute_value = 7'(digit_val(ln[23])) * 7'd10 + 7'(digit_val(ln[24]));
            res.second_value = 7'(digit_val(ln[26])) * 7'd10 + 7'(digit_val(ln[27]));
        end
    end

    assign pop      = !q_empty && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_result = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= res;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/console_command_line_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// console_command_line_decoder_core
// Console line editor and command decoder, one result beat per nonempty line.
//
//   Channel  Dir  Payload                                    Handshake
//   s_       in   s_tdata[7:0]   rx_byte                     s_tvalid/s_tready
//   m_       out  m_tdata[55:0]  command, status, date-time  m_tvalid/m_tready
//   cfg_     in   cfg_wdata      clock_present               cfg_we
//
// One byte per cycle while s_tready is high; a newline's result beat passes
// through the line queue and then the decode output register.
// Synchronous reset clears the line length, overflow mark, queue, output
// valid and clock_present; the line store itself is not cleared.
// s_tready drops only while the two-entry line queue is full, which happens
// when result beats are held off by m_tready.
// ----------------------------------------------------------------------------
module console_command_line_decoder_core import ccld_pkg::*; #(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // rx_byte[7:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // command_code[2:0], status[5:3], year_value[19:6], month_value[26:20],
    // day_value[33:27], hour_value[40:34], minute_value[47:41],
    // second_value[54:48], zero pad[55]
    output logic [M_TDATA_W-1:0]      m_tdata,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_wdata
);

    logic    clock_present_reg;
    logic    push, pop, q_full, q_empty;
    token_t  push_token, head;
    result_t m_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_present_reg <= 1'b0;
        end else if (cfg_we) begin
            clock_present_reg <= cfg_wdata;
        end
    end

    ccld_front #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_full     (q_full),
        .push       (push),
        .push_token (push_token)
    );

    ccld_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_token (push_token),
        .pop        (pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (head)
    );

    ccld_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .clock_present (clock_present_reg),
        .q_empty       (q_empty),
        .head          (head),
        .pop           (pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_result      (m_result)
    );

    assign m_tdata = {{(M_TDATA_W - RESULT_W){1'b0}}, m_result};

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("line pushed into full queue");

    a_push_on_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (s_tvalid && s_tready && s_tdata == CHAR_LF))
        else $error("line pushed without newline beat");

    a_pop_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_empty)
        else $error("pop from empty queue");

    a_error_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_result.status != ST_OK) |-> (m_tdata[54:6] == '0))
        else $error("error beat carries date-time fields");

endmodule
`default_nettype wire

FILE: verif/ccld_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccld_reply_checker
// Watches the byte, reply and config channels of the console line decoder,
// keeps its own line store, works out the reply for every newline and checks
// each reply beat field by field, in order.
// ----------------------------------------------------------------------------
module ccld_reply_checker import ccld_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [7:0]           s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_wdata,
    output int                        errors,
    output int                        replies_due,
    output int                        replies_checked
);

    localparam int CAP       = LINE_CAPACITY_DEF;
    localparam int STAMP_LEN = 19;

    logic [7:0] line_buf [CAP];
    int         line_len;
    bit         overflow;
    bit         clock_on;
    result_t    due_replies [$];

    initial begin
        errors          = 0;
        replies_due     = 0;
        replies_checked = 0;
        line_len        = 0;
        overflow        = 1'b0;
        clock_on        = 1'b0;
        for (int i = 0; i < CAP; i++) begin
            line_buf[i] = 8'h00;
        end
    end

    function automatic bit starts_with(input logic [8*WORD_MAX-1:0] word, input int n);
        bit ok;
        ok = (line_len >= n);
        for (int i = 0; i < n; i++) begin
            if (ok && line_buf[i] != word[8*(n-1-i) +: 8]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic bit line_equals(input logic [8*WORD_MAX-1:0] word, input int n);
        return (line_len == n) && starts_with(word, n);
    endfunction

    function automatic bit digits_at(input int pos, input int n, output int val);
        logic [7:0] c;
        bit         ok;
        ok  = 1'b1;
        val = 0;
        for (int i = 0; i < n; i++) begin
            c = line_buf[pos + i];
            if (c < CHAR_ZERO || c > CHAR_NINE) begin
                ok = 1'b0;
            end else begin
                val = val * 10 + int'(c - CHAR_ZERO);
            end
        end
        return ok;
    endfunction

    function automatic result_t decode_command_line();
        result_t r;
        int      yr, mo, dy, hr, mi, se;
        int      b;
        bit      is_get, is_set, good;
        r              = '0;
        r.command_code = CMD_NONE;
        r.status       = ST_OK;
        b              = PREFIX_LEN;
        if (line_equals(W_HELP, 4)) begin
            r.command_code = CMD_HELP;
        end else if (line_equals(W_SETTINGS, 12)) begin
            r.command_code = CMD_SETTINGS;
        end else if (line_equals(W_AUDIO, 9)) begin
            r.command_code = CMD_AUDIO;
        end else if (line_equals(W_NETWORK, 11)) begin
            r.command_code = CMD_NETWORK;
        end else if (line_equals(W_WIFI, 10)) begin
            r.command_code = CMD_WIFI;
        end else begin
            is_get = line_equals(W_CLK_READ, 8);
            is_set = starts_with(W_CLK_PREFIX, PREFIX_LEN);
            if (!is_get && !is_set) begin
                r.status = ST_UNKNOWN;
            end else begin
                r.command_code = is_get ? CMD_CLOCK_RD : CMD_CLOCK_WR;
                if (!clock_on) begin
                    r.status = ST_NO_CLOCK;
                end else if (is_set) begin
                    good = 1'b0;
                    if (line_len == PREFIX_LEN + STAMP_LEN) begin
                        good = line_buf[b + 4] == CHAR_DASH && line_buf[b + 7] == CHAR_DASH
                            && line_buf[b + 10] == CHAR_SPACE
                            && line_buf[b + 13] == CHAR_COLON
                            && line_buf[b + 16] == CHAR_COLON;
                        good = digits_at(b, 4, yr) && good;
                        good = digits_at(b + 5, 2, mo) && good;
                        good = digits_at(b + 8, 2, dy) && good;
                        good = digits_at(b + 11, 2, hr) && good;
                        good = digits_at(b + 14, 2, mi) && good;
                        good = digits_at(b + 17, 2, se) && good;
                    end
                    if (good) begin
                        r.year_value   = yr[13:0];
                        r.month_value  = mo[6:0];
                        r.day_value    = dy[6:0];
                        r.hour_value   = hr[6:0];
                        r.minute_value = mi[6:0];
                        r.second_value = se[6:0];
                    end else begin
                        r.status = ST_BAD_TIME;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic take_byte(input logic [7:0] c);
        result_t r;
        if (c == CHAR_BS || c == CHAR_DEL) begin
            if (line_len > 0) begin
                line_len--;
            end
        end else if (c == CHAR_LF) begin
            if (overflow) begin
                r              = '0;
                r.command_code = CMD_NONE;
                r.status       = ST_TOO_LONG;
                due_replies.push_back(r);
            end else if (line_len > 0) begin
                due_replies.push_back(decode_command_line());
            end
            line_len = 0;
            overflow = 1'b0;
        end else if (c >= CHAR_SPACE && c <= CHAR_TILDE) begin
            if (line_len < CAP) begin
                line_buf[line_len] = c;
                line_len++;
            end else begin
                overflow = 1'b1;
            end
        end
    endtask

    task automatic compare_field(input string name, input int want, input int seen);
        if (want != seen) begin
            errors++;
            $display("%0t ERROR reply %0d %s: expected %0d, got %0d",
                     $time, replies_checked, name, want, seen);
        end
    endtask

    task automatic check_reply(input logic [M_TDATA_W-1:0] beat);
        result_t want, seen;
        seen = beat[RESULT_W-1:0];
        if (due_replies.size() == 0) begin
            errors++;
            $display("%0t ERROR unexpected reply beat: expected none, got %h", $time, beat);
        end else begin
            want = due_replies.pop_front();
            compare_field("command_code", int'(want.command_code), int'(seen.command_code));
            compare_field("status", int'(want.status), int'(seen.status));
            compare_field("year_value", int'(want.year_value), int'(seen.year_value));
            compare_field("month_value", int'(want.month_value), int'(seen.month_value));
            compare_field("day_value", int'(want.day_value), int'(seen.day_value));
            compare_field("hour_value", int'(want.hour_value), int'(seen.hour_value));
            compare_field("minute_value", int'(want.minute_value), int'(seen.minute_value));
            compare_field("second_value", int'(want.second_value), int'(seen.second_value));
            replies_checked++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            line_len = 0;
            overflow = 1'b0;
            clock_on = 1'b0;
            due_replies.delete();
        end else begin
            if (cfg_we) begin
                clock_on = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                take_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                check_reply(m_tdata);
            end
        end
        replies_due = due_replies.size();
    end

endmodule

FILE: verif/console_command_line_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_command_line_decoder_core_tb
// Feeds console bytes to the line decoder: hand-written lines for every
// command, status and editing corner, then random well-formed and broken
// lines under both clock settings, with bursty valid/ready and one long
// reply hold-off. Checking is done by ccld_reply_checker.
// ----------------------------------------------------------------------------
module console_command_line_decoder_core_tb;
    import ccld_pkg::*;

    localparam int ITEM_TARGET = 1600;
    localparam int PHASE_ITEMS = 275;
    localparam int CYCLE_LIMIT = 400000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [7:0]           s_tdata   = 8'h00;
    logic                 m_tready  = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_wdata = 1'b0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [M_TDATA_W-1:0] m_tdata;

    int         errors;
    int         replies_due;
    int         replies_checked;
    int         bytes_sent = 0;
    int         cycles     = 0;
    bit         hold_req   = 1'b0;
    bit         quiet_end  = 1'b0;
    bit         src_bursty = 1'b0;
    logic [7:0] line_bytes [$];

    always #5 aclk = ~aclk;

    console_command_line_decoder_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    ccld_reply_checker reply_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .errors          (errors),
        .replies_due     (replies_due),
        .replies_checked (replies_checked)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL console_command_line_decoder_core");
            $finish;
        end
    end

    // reply side: random ready bursts, calm stretches, one long hold-off
    initial begin : reply_sink
        int hold_cnt;
        int span_left;
        bit calm;
        span_left = 0;
        calm      = 1'b0;
        forever begin
            @(negedge aclk);
            if (span_left == 0) begin
                calm      = ($urandom_range(0, 3) == 0);
                span_left = 100;
            end
            span_left--;
            if (hold_req) begin
                m_tready = 1'b0;
                hold_cnt = 0;
                while (hold_cnt < 400) begin
                    @(negedge aclk);
                    hold_cnt++;
                end
                hold_req = 1'b0;
            end else if (!quiet_end && !calm && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (!quiet_end && src_bursty && $urandom_range(0, 6) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (b == CHAR_BS || b == CHAR_DEL || b == CHAR_LF || (b >= CHAR_SPACE && b <= CHAR_TILDE)) begin
            bytes_sent++;
        end
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            line_bytes.push_back(s[i]);
        end
    endtask

    // first k chars of an n-char command word
    task automatic push_word(input logic [8*WORD_MAX-1:0] w, input int n, input int k);
        for (int i = 0; i < k; i++) begin
            line_bytes.push_back(w[8*(n-1-i) +: 8]);
        end
    endtask

    task automatic push_cmd(input int idx);
        case (idx)
            0: push_word(W_HELP, 4, 4);
            1: push_word(W_SETTINGS, 12, 12);
            2: push_word(W_AUDIO, 9, 9);
            3: push_word(W_NETWORK, 11, 11);
            4: push_word(W_WIFI, 10, 10);
            5: push_word(W_CLK_READ, 8, 8);
            default: push_word(W_CLK_PREFIX, PREFIX_LEN, PREFIX_LEN - 1);
        endcase
    endtask

    task automatic push_fill(input logic [7:0] c, input int n);
        repeat (n) line_bytes.push_back(c);
    endtask

    task automatic end_line(input bit with_cr);
        if (with_cr) begin
            line_bytes.push_back(CHAR_CR);
        end
        line_bytes.push_back(CHAR_LF);
        foreach (line_bytes[i]) begin
            send_byte(line_bytes[i]);
        end
        line_bytes.delete();
    endtask

    task automatic text_line(input string s);
        push_text(s);
        end_line(1'b0);
    endtask

    task automatic word_line(input logic [8*WORD_MAX-1:0] w, input int n);
        push_word(w, n, n);
        end_line(1'b0);
    endtask

    task automatic stamp_line(input string s);
        push_word(W_CLK_PREFIX, PREFIX_LEN, PREFIX_LEN);
        text_line(s);
    endtask

    task automatic set_clock(input bit present);
        s_tvalid = 1'b0;
        while (replies_due != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = present;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    function automatic logic [7:0] ignored_byte();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while ((c >= CHAR_SPACE && c <= CHAR_DEL) || c == CHAR_BS || c == CHAR_LF
                   || c == CHAR_CR);
        return c;
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(32, 126));
    endfunction

    task automatic push_stamp();
        push_word(W_CLK_PREFIX, PREFIX_LEN, PREFIX_LEN);
        push_text($sformatf("%04d-%02d-%02d %02d:%02d:%02d",
                            $urandom_range(0, 9999), $urandom_range(0, 99),
                            $urandom_range(0, 99), $urandom_range(0, 99),
                            $urandom_range(0, 99), $urandom_range(0, 99)));
    endtask

    task automatic random_line();
        int kind;
        int pos;
        int n;
        kind       = $urandom_range(0, 99);
        src_bursty = ($urandom_range(0, 3) != 0);
        if (kind < 30) begin
            push_stamp();
        end else if (kind < 45) begin
            push_cmd($urandom_range(0, 5));
        end else if (kind < 55) begin
            push_stamp();
            case ($urandom_range(0, 2))
                0: line_bytes[$urandom_range(9, 27)] = printable();
                1: void'(line_bytes.pop_back());
                default: line_bytes.push_back(printable());
            endcase
        end else if (kind < 65) begin
            push_cmd($urandom_range(0, 6));
            if ($urandom_range(0, 1) == 0) begin
                line_bytes[$urandom_range(0, line_bytes.size() - 1)] = printable();
            end else begin
                line_bytes.push_back(printable());
            end
        end else if (kind < 75) begin
            n = $urandom_range(1, 20);
            repeat (n) line_bytes.push_back(printable());
        end else if (kind < 82) begin
            n = $urandom_range(60, 75);
            repeat (n) line_bytes.push_back(printable());
            n = $urandom_range(0, 15);
            repeat (n) line_bytes.push_back(($urandom_range(0, 1) == 0) ? CHAR_BS : CHAR_DEL);
        end else if (kind < 87) begin
            n = $urandom_range(0, 3);
            repeat (n) line_bytes.push_back(CHAR_BS);
        end else begin
            n = $urandom_range(1, 15);
            repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
        end
        // typo fixed by a backspace
        if ($urandom_range(0, 5) == 0) begin
            pos = $urandom_range(0, line_bytes.size());
            line_bytes.insert(pos, printable());
            line_bytes.insert(pos + 1, ($urandom_range(0, 1) == 0) ? CHAR_BS : CHAR_DEL);
        end
        if ($urandom_range(0, 9) == 0) begin
            line_bytes.insert($urandom_range(0, line_bytes.size()), ignored_byte());
        end
        end_line($urandom_range(0, 7) == 0);
    endtask

    initial begin : stimulus
        int rand_base;
        int phase_end;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // clock absent
        set_clock(1'b0);
        text_line("HELP");
        push_fill(CHAR_BS, 1);
        push_fill(CHAR_DEL, 1);
        word_line(W_SETTINGS, 12);
        push_word(W_AUDIO, 9, 9);
        end_line(1'b1);
        word_line(W_NETWORK, 11);
        word_line(W_WIFI, 10);
        word_line(W_CLK_READ, 8);
        stamp_line("2024-06-15 12:30:45");
        text_line("");
        push_text("X");
        push_fill(8'h01, 1);
        push_text("Y");
        push_fill(8'h1f, 1);
        push_fill(8'h80, 1);
        push_text("Z");
        push_fill(8'hff, 1);
        end_line(1'b0);
        push_text("HELPX");
        push_fill(CHAR_DEL, 1);
        end_line(1'b0);

        // clock present
        set_clock(1'b1);
        word_line(W_CLK_READ, 8);
        stamp_line("9999-99-99 99:99:99");
        stamp_line("0000-00-00 00:00:00");
        stamp_line("2024/06-15 12:30:45");
        stamp_line("2024-06-15 12:3a:45");
        stamp_line("2024-06-15 12:30:4");
        stamp_line("");
        push_word(W_CLK_PREFIX, PREFIX_LEN, PREFIX_LEN - 1);
        end_line(1'b0);
        push_text(" ");
        push_fill(CHAR_TILDE, 62);
        end_line(1'b0);
        push_fill(8'h41, 64);
        end_line(1'b0);
        push_fill(8'h42, 70);
        push_fill(CHAR_BS, 20);
        end_line(1'b0);

        rand_base = bytes_sent;
        for (int ph = 0; ph < 4; ph++) begin
            set_clock(ph != 1);
            if (ph == 0) begin
                hold_req = 1'b1;
            end
            phase_end = rand_base + (ph + 1) * PHASE_ITEMS;
            while (bytes_sent < phase_end) begin
                random_line();
                if (bytes_sent >= ITEM_TARGET - 200) begin
                    quiet_end = 1'b1;
                end
            end
        end
        s_tvalid = 1'b0;

        while (replies_due != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("Run covered %0d console bytes and %0d checked replies over all commands,",
                 bytes_sent, replies_checked);
        $display("both clock settings, line overflow, editing bytes and a long reply hold-off.");
        if (errors == 0) begin
            $display("PASS console_command_line_decoder_core");
        end else begin
            $display("FAIL console_command_line_decoder_core");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ccld_pkg.sv
rtl/ccld_front.sv
rtl/ccld_queue.sv
rtl/ccld_back.sv
rtl/console_command_line_decoder_core.sv
verif/ccld_reply_checker.sv
verif/console_command_line_decoder_core_tb.sv
